@@ hw/rtl/crsf_pkg.sv @@
// ----------------------------------------------------------------------------
// CRSF receiver package
// Shared widths, register indexes, reset values, codes and the CRC-8 step.
// ----------------------------------------------------------------------------
package crsf_pkg;

  localparam int MAX_PAYLOAD_DEF = 60;

  localparam int BYTE_W    = 8;
  localparam int GAP_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int FLEN_W    = 7;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ADDR_RADIO  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_MODULE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_FLIGHT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 8'd3;

  localparam logic [BYTE_W-1:0] ADDR_RADIO_RST  = 8'hEA;
  localparam logic [BYTE_W-1:0] ADDR_MODULE_RST = 8'hEE;
  localparam logic [BYTE_W-1:0] ADDR_FLIGHT_RST = 8'hC8;
  localparam logic [GAP_W-1:0]  TIMEOUT_RST     = 16'd20;

  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd3;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  localparam logic [BYTE_W-1:0] RC_TYPE        = 8'h16;
  localparam logic [BYTE_W-1:0] RC_MIN_PAYLOAD = 8'd22;
  localparam logic [BYTE_W-1:0] MIN_LENGTH     = 8'd3;
  localparam logic [BYTE_W-1:0] CRC_POLY       = 8'hD5;

  typedef struct packed {
    logic [BYTE_W-1:0] addr_radio;
    logic [BYTE_W-1:0] addr_module;
    logic [BYTE_W-1:0] addr_flight;
    logic [GAP_W-1:0]  timeout_ms;
  } cfg_t;

  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/crsf_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// CRSF frame receiver
// The result of each input transfer is registered onto the master side in the
// cycle after it. Throughput: one byte per cycle; the parser state and running
// CRC-8 update on each accepted byte. A result that waits on the master side
// holds off the slave side, and a new byte enters in the cycle it is taken.
// Reset clears the parser state, counters and output valid, and restores the
// configuration registers to their default values.
// ----------------------------------------------------------------------------
module crsf_frame_receiver #(
  parameter int MAX_PAYLOAD = crsf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // rx_byte, gap_ms
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status, timed_out, frame_length, frame_type, rc_channels, good_total,
  // error_total, then five zero bits
  output logic [87:0]                    m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crsf_pkg::CFG_DAT_W-1:0] cfg_data
);
  import crsf_pkg::*;

  localparam int PW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [BYTE_W-1:0] MAX_LENGTH = BYTE_W'(MAX_PAYLOAD + 2);

  cfg_t cfg;

  crsf_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [BYTE_W-1:0] rx_byte;
  logic [GAP_W-1:0]  gap_ms;
  logic              accept;

  assign rx_byte  = s_tdata[BYTE_W-1:0];
  assign gap_ms   = s_tdata[BYTE_W+GAP_W-1:BYTE_W];
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  logic [2:0]         phase, phase_next;
  logic [PW-1:0]      payload_needed, payload_needed_next;
  logic [PW-1:0]      payload_seen, payload_seen_next;
  logic [BYTE_W-1:0]  crc_running, crc_running_next;
  logic [BYTE_W-1:0]  type_held, type_held_next;
  logic [COUNT_W-1:0] good_frames, good_frames_next;
  logic [COUNT_W-1:0] bad_events, bad_events_next;

  logic [STATUS_W-1:0] r_status, status_next;
  logic                r_timed_out, timed_out_next;
  logic [FLEN_W-1:0]   r_frame_length, frame_length_next;
  logic [BYTE_W-1:0]   r_frame_type, frame_type_next;
  logic                r_rc, rc_next;

  logic [2:0]    ph;
  logic          bad_hit;
  logic [PW-1:0] seen_inc;

  always_comb begin
    ph                  = phase;
    bad_hit             = 1'b0;
    timed_out_next      = 1'b0;
    status_next         = ST_NONE;
    frame_length_next   = '0;
    frame_type_next     = '0;
    rc_next             = 1'b0;
    payload_needed_next = payload_needed;
    payload_seen_next   = payload_seen;
    crc_running_next    = crc_running;
    type_held_next      = type_held;
    good_frames_next    = good_frames;
    seen_inc            = payload_seen + PW'(1);

    if (phase != PH_HUNT && gap_ms > cfg.timeout_ms) begin
      ph             = PH_HUNT;
      bad_hit        = 1'b1;
      timed_out_next = 1'b1;
    end

    phase_next = ph;
    case (ph)
      PH_HUNT: begin
        if (rx_byte == cfg.addr_radio || rx_byte == cfg.addr_module ||
            rx_byte == cfg.addr_flight) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (rx_byte < MIN_LENGTH || rx_byte > MAX_LENGTH) begin
          phase_next  = PH_HUNT;
          bad_hit     = 1'b1;
          status_next = ST_LEN_ERR;
        end else begin
          payload_needed_next = PW'(rx_byte - 8'd2);
          payload_seen_next   = '0;
          crc_running_next    = '0;
          phase_next          = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_held_next   = rx_byte;
        crc_running_next = crc8_step('0, rx_byte);
        phase_next       = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_running_next  = crc8_step(crc_running, rx_byte);
        payload_seen_next = seen_inc;
        if (seen_inc >= payload_needed) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        phase_next        = PH_HUNT;
        frame_length_next = FLEN_W'(payload_needed) + FLEN_W'(4);
        frame_type_next   = type_held;
        if (crc_running == rx_byte) begin
          good_frames_next = good_frames + COUNT_W'(1);
          status_next      = ST_GOOD;
          rc_next          = (type_held == RC_TYPE) &&
                             (BYTE_W'(payload_needed) >= RC_MIN_PAYLOAD);
        end else begin
          bad_hit     = 1'b1;
          status_next = ST_CRC_ERR;
        end
      end
      default: begin
        phase_next = PH_HUNT;
        bad_hit    = 1'b1;
      end
    endcase

    bad_events_next = bad_events + COUNT_W'(bad_hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      payload_needed <= '0;
      payload_seen   <= '0;
      crc_running    <= '0;
      type_held      <= '0;
      good_frames    <= '0;
      bad_events     <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        payload_needed <= payload_needed_next;
        payload_seen   <= payload_seen_next;
        crc_running    <= crc_running_next;
        type_held      <= type_held_next;
        good_frames    <= good_frames_next;
        bad_events     <= bad_events_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_status       <= status_next;
      r_timed_out    <= timed_out_next;
      r_frame_length <= frame_length_next;
      r_frame_type   <= frame_type_next;
      r_rc           <= rc_next;
    end
  end

  assign m_tdata = {5'b0, bad_events, good_frames, r_rc, r_frame_type,
                    r_frame_length, r_timed_out, r_status};

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted byte produced no result");

  a_good_counts: assert property (@(posedge clk) disable iff (rst)
    accept |=> good_frames == $past(good_frames) +
               COUNT_W'(r_status == ST_GOOD))
    else $error("good frame counter out of step with status");

  a_rc_needs_good: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r_rc) |-> (r_status == ST_GOOD))
    else $error("rc_channels flagged on a frame that is not good");

  a_timeout_counts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (!r_timed_out || bad_events == $past(bad_events) + COUNT_W'(1)))
    else $error("timeout not counted as an error");

endmodule

@@ hw/rtl/crsf_cfg.sv @@
// ----------------------------------------------------------------------------
// CRSF configuration registers
// Holds the three sync addresses and the inter-byte timeout.
// ----------------------------------------------------------------------------
module crsf_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crsf_pkg::CFG_DAT_W-1:0]    cfg_data,
  output crsf_pkg::cfg_t                    cfg
);
  import crsf_pkg::*;

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.addr_radio  <= ADDR_RADIO_RST;
      regs.addr_module <= ADDR_MODULE_RST;
      regs.addr_flight <= ADDR_FLIGHT_RST;
      regs.timeout_ms  <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADDR_RADIO:  regs.addr_radio  <= cfg_data[BYTE_W-1:0];
        REG_ADDR_MODULE: regs.addr_module <= cfg_data[BYTE_W-1:0];
        REG_ADDR_FLIGHT: regs.addr_flight <= cfg_data[BYTE_W-1:0];
        REG_TIMEOUT:     regs.timeout_ms  <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
